>>> rtl/core/homogeneous_vertex_transform_defines.svh
// ----------------------------------------------------------------------------
// homogeneous vertex transform assertion macros
// shared assertion helpers, empty in synthesis
// ----------------------------------------------------------------------------
`ifndef HOMOGENEOUS_VERTEX_TRANSFORM_DEFINES_SVH
`define HOMOGENEOUS_VERTEX_TRANSFORM_DEFINES_SVH

`ifndef SYNTHESIS
`define HVT_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define HVT_ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("assertion failed");
`else
`define HVT_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`define HVT_ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif

`endif

>>> rtl/core/hvt_pkg.sv
// ----------------------------------------------------------------------------
// hvt_pkg
// widths, opcodes and shared types of the vertex transform
// ----------------------------------------------------------------------------
`default_nettype none

package hvt_pkg;

    localparam int VW      = 32;
    localparam int FB      = 16;
    localparam int PW      = 2 * VW;
    localparam int SW      = 2 * VW + 2;
    localparam int MW      = SW - 1;
    localparam int NW      = MW + FB;
    localparam int QW      = VW;
    localparam int CW      = MW + QW;
    localparam int DIV_LAT = QW + 1;
    localparam int QD      = 4;
    localparam int QAW     = $clog2(QD);
    localparam int QCW     = $clog2(QD + 1);

    localparam logic [2:0] OP_LOAD    = 3'd0;
    localparam logic [2:0] OP_PT_COL  = 3'd1;
    localparam logic [2:0] OP_PT_ROW  = 3'd2;
    localparam logic [2:0] OP_DIR_COL = 3'd3;
    localparam logic [2:0] OP_DIR_ROW = 3'd4;

    typedef struct packed {
        logic           is_load;
        logic           point;
        logic           trans;
        logic [3:0]     idx;
        logic [VW-1:0]  val;
        logic [VW-1:0]  x;
        logic [VW-1:0]  y;
        logic [VW-1:0]  z;
    } t_q_entry;

    typedef struct packed {
        logic                 point;
        logic                 zero;
        logic [2:0]           neg;
        logic [2:0][VW-1:0]   dval;
        logic                 dsat;
    } t_side;

endpackage

`default_nettype wire

>>> rtl/core/hvt_front.sv
// ----------------------------------------------------------------------------
// hvt_front
// accepts beats, decodes the opcode and queues work for the back end
// ----------------------------------------------------------------------------
`default_nettype none

module hvt_front import hvt_pkg::*; (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    input  wire logic [2:0]     i_opcode,
    input  wire logic [3:0]     i_entry_index,
    input  wire logic [VW-1:0]  i_entry_value,
    input  wire logic [VW-1:0]  i_in_x,
    input  wire logic [VW-1:0]  i_in_y,
    input  wire logic [VW-1:0]  i_in_z,
    input  wire logic           i_pop,
    output logic                o_avail,
    output t_q_entry            o_entry
);

    t_q_entry         r_mem [0:QD-1];
    logic [QAW-1:0]   r_wptr, r_rptr;
    logic [QCW-1:0]   r_cnt, n_cnt;
    logic             keep, push, pop;
    t_q_entry         w_entry;

    always_comb begin
        w_entry         = '0;
        w_entry.idx     = i_entry_index;
        w_entry.val     = i_entry_value;
        w_entry.x       = i_in_x;
        w_entry.y       = i_in_y;
        w_entry.z       = i_in_z;
        keep            = 1'b1;
        case (i_opcode)
            OP_LOAD:    w_entry.is_load = 1'b1;
            OP_PT_COL:  w_entry.point   = 1'b1;
            OP_PT_ROW: begin
                w_entry.point = 1'b1;
                w_entry.trans = 1'b1;
            end
            OP_DIR_COL: w_entry.point   = 1'b0;
            OP_DIR_ROW: w_entry.trans   = 1'b1;
            default:    keep            = 1'b0;
        endcase
    end

    assign o_in_ready = (r_cnt != QCW'(QD));
    assign o_avail    = (r_cnt != '0);
    assign push       = i_in_valid && o_in_ready && keep;
    assign pop        = i_pop && o_avail;
    assign o_entry    = r_mem[r_rptr];

    always_comb begin
        n_cnt = r_cnt;
        case ({push, pop})
            2'b10:   n_cnt = r_cnt + 1'b1;
            2'b01:   n_cnt = r_cnt - 1'b1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wptr] <= w_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/hvt_div.sv
// ----------------------------------------------------------------------------
// hvt_div
// pipelined restoring divider, one quotient bit per stage, overflow check
// ----------------------------------------------------------------------------
`default_nettype none

module hvt_div import hvt_pkg::*; (
    input  wire logic           i_clk,
    input  wire logic           i_en,
    input  wire logic [MW-1:0]  i_num,
    input  wire logic [MW-1:0]  i_den,
    output logic                o_ovf,
    output logic [QW-1:0]       o_quo
);

    logic [CW-1:0]  r_rem [0:QW-1];
    logic [MW-1:0]  r_den [0:QW-1];
    logic [QW-1:0]  r_quo [0:QW];
    logic           r_ovf [0:QW];
    logic [CW-1:0]  n0;

    assign n0 = {{(CW-NW){1'b0}}, i_num, {FB{1'b0}}};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= n0;
            r_den[0] <= i_den;
            r_quo[0] <= '0;
            r_ovf[0] <= (n0 >= {i_den, {QW{1'b0}}});
        end
    end

    for (genvar k = 1; k <= QW; k++) begin : g_stage
        logic [CW-1:0] trial;
        logic          ge;
        assign trial = {{QW{1'b0}}, r_den[k-1]} << (QW - k);
        assign ge    = (r_rem[k-1] >= trial);
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_quo[k] <= r_quo[k-1] | (ge ? (QW'(1) << (QW - k)) : '0);
                r_ovf[k] <= r_ovf[k-1];
            end
        end
        if (k < QW) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k] <= ge ? (r_rem[k-1] - trial) : r_rem[k-1];
                    r_den[k] <= r_den[k-1];
                end
            end
        end
    end

    assign o_ovf = r_ovf[QW];
    assign o_quo = r_quo[QW];

endmodule

`default_nettype wire

>>> rtl/core/hvt_back.sv
// ----------------------------------------------------------------------------
// hvt_back
// holds the matrix, forms the dot products, divides, clamps, output register
// ----------------------------------------------------------------------------
`default_nettype none

module hvt_back import hvt_pkg::*; (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_avail,
    input  wire t_q_entry       i_entry,
    output logic                o_pop,
    output logic                o_out_valid,
    input  wire logic           i_out_ready,
    output logic [VW-1:0]       o_out_x,
    output logic [VW-1:0]       o_out_y,
    output logic [VW-1:0]       o_out_z,
    output logic                o_divide_fault,
    output logic                o_saturated
);

    localparam logic [VW-1:0] ONE  = VW'(1) << FB;
    localparam logic [VW-1:0] VMAX = {1'b0, {(VW-1){1'b1}}};
    localparam logic [VW-1:0] VMIN = {1'b1, {(VW-1){1'b0}}};

    logic [VW-1:0]  r_mat [0:15];
    logic           en;

    // stage 1: products
    logic [3:0][2:0][PW-1:0] r_p;
    logic [3:0][VW-1:0]      r_t;
    logic                    r_v1, r_pt1;
    // stage 2: sums
    logic [3:0][SW-1:0]      r_s;
    logic                    r_v2, r_pt2;
    // stage 3: magnitudes and direction results
    logic [2:0][MW-1:0]      r_num;
    logic [MW-1:0]           r_den;
    t_side                   r_sd3;
    logic                    r_v3;
    t_side                   r_side [0:DIV_LAT-1];
    logic                    r_vs   [0:DIV_LAT-1];

    logic [2:0]              ovf;
    logic [2:0][QW-1:0]      quo;
    logic [VW-1:0]           r_ox, r_oy, r_oz;
    logic                    r_of, r_os, r_ov;

    function automatic logic [VW-1:0] elem_of(input logic [VW-1:0] m [0:15],
                                             input logic tr, input int r, input int c);
        logic [3:0] a;
        a = tr ? 4'(c * 4 + r) : 4'(r * 4 + c);
        return m[a];
    endfunction

    assign en          = !r_ov || i_out_ready;
    assign o_pop       = i_avail && en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 16; i++) begin
                r_mat[i] <= (i % 5 == 0) ? ONE : '0;
            end
        end else if (o_pop && i_entry.is_load) begin
            r_mat[i_entry.idx] <= i_entry.val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int r = 0; r < 4; r++) begin
                r_p[r][0] <= PW'($signed(elem_of(r_mat, i_entry.trans, r, 0))
                                 * $signed(i_entry.x));
                r_p[r][1] <= PW'($signed(elem_of(r_mat, i_entry.trans, r, 1))
                                 * $signed(i_entry.y));
                r_p[r][2] <= PW'($signed(elem_of(r_mat, i_entry.trans, r, 2))
                                 * $signed(i_entry.z));
                r_t[r]    <= elem_of(r_mat, i_entry.trans, r, 3);
            end
            r_pt1 <= i_entry.point;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int r = 0; r < 4; r++) begin
                r_s[r] <= SW'($signed(r_p[r][0])) + SW'($signed(r_p[r][1]))
                        + SW'($signed(r_p[r][2]))
                        + (r_pt1 ? (SW'($signed(r_t[r])) <<< FB) : '0);
            end
            r_pt2 <= r_pt1;
        end
    end

    always_ff @(posedge i_clk) begin
        logic [SW-1:0] d;
        logic          wn, nn, fit, ds;
        if (en) begin
            wn           = r_s[3][SW-1];
            ds           = 1'b0;
            r_den        <= MW'(wn ? (~r_s[3] + 1'b1) : r_s[3]);
            r_sd3.point  <= r_pt2;
            r_sd3.zero   <= (r_s[3] == '0);
            for (int i = 0; i < 3; i++) begin
                nn          = r_s[i][SW-1];
                r_num[i]    <= MW'(nn ? (~r_s[i] + 1'b1) : r_s[i]);
                r_sd3.neg[i] <= nn ^ wn;
                d           = SW'($signed(r_s[i]) >>> FB);
                fit         = (d[SW-1:VW-1] == '0) || (d[SW-1:VW-1] == '1);
                ds          = ds || !fit;
                if (fit) begin
                    r_sd3.dval[i] <= d[VW-1:0];
                end else begin
                    r_sd3.dval[i] <= d[SW-1] ? VMIN : VMAX;
                end
            end
            r_sd3.dsat <= ds;
        end
    end

    for (genvar i = 0; i < 3; i++) begin : g_div
        hvt_div u_div (
            .i_clk (i_clk),
            .i_en  (en),
            .i_num (r_num[i]),
            .i_den (r_den),
            .o_ovf (ovf[i]),
            .o_quo (quo[i])
        );
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_side[0] <= r_sd3;
            for (int k = 1; k < DIV_LAT; k++) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_ov <= 1'b0;
            for (int k = 0; k < DIV_LAT; k++) begin
                r_vs[k] <= 1'b0;
            end
        end else if (en) begin
            r_v1    <= o_pop && !i_entry.is_load;
            r_v2    <= r_v1;
            r_v3    <= r_v2;
            r_vs[0] <= r_v3;
            for (int k = 1; k < DIV_LAT; k++) begin
                r_vs[k] <= r_vs[k-1];
            end
            r_ov <= r_vs[DIV_LAT-1];
        end
    end

    always_ff @(posedge i_clk) begin
        t_side          sd;
        logic [VW-1:0]  res [0:2];
        logic           sat, big;
        if (en) begin
            sd  = r_side[DIV_LAT-1];
            sat = 1'b0;
            for (int i = 0; i < 3; i++) begin
                big = ovf[i] || (quo[i][QW-1] &&
                      (!sd.neg[i] || (quo[i][QW-2:0] != '0)));
                if (!sd.point) begin
                    res[i] = sd.dval[i];
                end else if (sd.zero) begin
                    res[i] = '0;
                end else if (big) begin
                    res[i] = sd.neg[i] ? VMIN : VMAX;
                    sat    = 1'b1;
                end else begin
                    res[i] = sd.neg[i] ? (~quo[i] + 1'b1) : quo[i];
                end
            end
            r_ox <= res[0];
            r_oy <= res[1];
            r_oz <= res[2];
            r_of <= sd.point && sd.zero;
            r_os <= sd.point ? (sat && !sd.zero) : sd.dsat;
        end
    end

    assign o_out_valid    = r_ov;
    assign o_out_x        = r_ox;
    assign o_out_y        = r_oy;
    assign o_out_z        = r_oz;
    assign o_divide_fault = r_of;
    assign o_saturated    = r_os;

endmodule

`default_nettype wire

>>> rtl/core/homogeneous_vertex_transform.sv
// throughput: one beat per cycle while the output is not stalled, set by the
//   fully pipelined multipliers and the one-bit-per-stage divider pipeline
//   (32 quotient stages plus an overflow check)
// a load beat updates the matrix when it leaves the queue and gives no result
// reset: synchronous active low, empties queue and pipeline, matrix set to identity
// ----------------------------------------------------------------------------
// homogeneous_vertex_transform
// 4x4 matrix transform of vertices, perspective divide for points, top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "homogeneous_vertex_transform_defines.svh"

module homogeneous_vertex_transform import hvt_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire logic [2:0]            i_opcode,
    input  wire logic [3:0]            i_entry_index,
    input  wire logic signed [VW-1:0]  i_entry_value,
    input  wire logic signed [VW-1:0]  i_in_x,
    input  wire logic signed [VW-1:0]  i_in_y,
    input  wire logic signed [VW-1:0]  i_in_z,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output logic signed [VW-1:0]       o_out_x,
    output logic signed [VW-1:0]       o_out_y,
    output logic signed [VW-1:0]       o_out_z,
    output logic                       o_divide_fault,
    output logic                       o_saturated
);

    localparam logic [VW-1:0] VMAX = {1'b0, {(VW-1){1'b1}}};
    localparam logic [VW-1:0] VMIN = {1'b1, {(VW-1){1'b0}}};

    logic      avail, pop;
    t_q_entry  entry;

    hvt_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_opcode      (i_opcode),
        .i_entry_index (i_entry_index),
        .i_entry_value (i_entry_value),
        .i_in_x        (i_in_x),
        .i_in_y        (i_in_y),
        .i_in_z        (i_in_z),
        .i_pop         (pop),
        .o_avail       (avail),
        .o_entry       (entry)
    );

    hvt_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_avail        (avail),
        .i_entry        (entry),
        .o_pop          (pop),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_out_x        (o_out_x),
        .o_out_y        (o_out_y),
        .o_out_z        (o_out_z),
        .o_divide_fault (o_divide_fault),
        .o_saturated    (o_saturated)
    );

    `HVT_ASSERT_IMPLIES(a_fault_zero, i_clk, i_rst_n, o_out_valid && o_divide_fault, !o_saturated && o_out_x == '0 && o_out_y == '0 && o_out_z == '0)
    `HVT_ASSERT_IMPLIES(a_sat_clamped, i_clk, i_rst_n, o_out_valid && o_saturated, o_out_x == VMAX || o_out_x == VMIN || o_out_y == VMAX || o_out_y == VMIN || o_out_z == VMAX || o_out_z == VMIN)
    `HVT_ASSERT_NEVER(a_pop_empty, i_clk, i_rst_n, pop && !avail)

endmodule

`default_nettype wire
